// ===== sv/pcss_pkg.sv =====
// ----------------------------------------------------------------------------
// pcss_pkg
// Shared types and constants for the power converter startup sequencer:
// mode codes, blink timing, register indexes and the stream word layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package pcss_pkg;

  // Configuration register indexes and widths
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;
  localparam logic [CfgIndexW-1:0] REG_STARTUP_TIMEOUT = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_PLL_TIMEOUT     = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_RETRY_LIMIT     = 2'd2;

  localparam logic [15:0] STARTUP_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] PLL_TIMEOUT_RST     = 16'd2000;
  localparam logic [7:0]  RETRY_LIMIT_RST     = 8'd3;

  // Mode codes as seen on the result word
  localparam logic [3:0] MODE_POWERON  = 4'd0;
  localparam logic [3:0] MODE_STANDBY  = 4'd1;
  localparam logic [3:0] MODE_PLLLOCK  = 4'd2;
  localparam logic [3:0] MODE_PFCRAMP  = 4'd3;
  localparam logic [3:0] MODE_LLCRAMP  = 4'd4;
  localparam logic [3:0] MODE_RUN      = 4'd5;
  localparam logic [3:0] MODE_FAULT    = 4'd7;
  localparam logic [3:0] MODE_DISABLED = 4'd9;

  // Fault codes
  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_PLL     = 2'd1;
  localparam logic [1:0] FAULT_STARTUP = 2'd2;

  // Blink timing: every blink period is a multiple of a 50-tick slot.
  // PLL and LLC toggle every 2 slots, PFC every slot, disabled every 10 slots.
  localparam int SlotTicks     = 50;
  localparam int DisabledSlots = 10;
  localparam int SlotCntW      = $clog2(SlotTicks);
  localparam int SlotMod20W    = $clog2(2 * DisabledSlots);
  localparam logic [SlotCntW-1:0]   SLOT_LAST    = SlotCntW'(SlotTicks - 1);
  localparam logic [SlotMod20W-1:0] SLOT20_LAST  = SlotMod20W'(2 * DisabledSlots - 1);
  localparam logic [SlotMod20W-1:0] SLOT20_HALF  = SlotMod20W'(DisabledSlots);

  localparam int TimeW = 32;

  // Sequencer state, one-hot
  typedef enum logic [7:0] {
    ST_POWERON  = 8'b0000_0001,
    ST_STANDBY  = 8'b0000_0010,
    ST_PLLLOCK  = 8'b0000_0100,
    ST_PFCRAMP  = 8'b0000_1000,
    ST_LLCRAMP  = 8'b0001_0000,
    ST_RUN      = 8'b0010_0000,
    ST_FAULT    = 8'b0100_0000,
    ST_DISABLED = 8'b1000_0000
  } state_t;

  // Input word, lowest field in bit 0 (24 bits)
  typedef struct packed {
    logic [6:0] pad;
    logic       fault_present;
    logic [7:0] retry_attempts;
    logic       fault_latched;
    logic       fault_cleared;
    logic       llc_ramp_done;
    logic       pfc_ramp_done;
    logic       pll_locked;
    logic       adc_cal_valid;
    logic       dll_locked;
    logic       enable_request;
  } in_word_t;

  // Result word, lowest field in bit 0 (16 bits)
  typedef struct packed {
    logic       balance_update;
    logic       relays_off;
    logic [1:0] fault_code;
    logic       ramp_step;
    logic       ramp_begin;
    logic       pll_reset;
    logic       llc_stop;
    logic       pfc_stop;
    logic       pfc_start;
    logic       mode_changed;
    logic       led;
    logic [3:0] mode;
  } out_word_t;

  localparam int InW  = $bits(in_word_t);
  localparam int OutW = $bits(out_word_t);

  // Map a state to its external mode code
  function automatic logic [3:0] mode_code(state_t st);
    logic [3:0] code;
    case (st)
      ST_POWERON:  code = MODE_POWERON;
      ST_STANDBY:  code = MODE_STANDBY;
      ST_PLLLOCK:  code = MODE_PLLLOCK;
      ST_PFCRAMP:  code = MODE_PFCRAMP;
      ST_LLCRAMP:  code = MODE_LLCRAMP;
      ST_RUN:      code = MODE_RUN;
      ST_FAULT:    code = MODE_FAULT;
      ST_DISABLED: code = MODE_DISABLED;
      default:     code = MODE_FAULT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== sv/power_converter_startup_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// power_converter_startup_sequencer_top
// Mode sequencer for a two-stage converter, advanced by one tick word at a
// time; each tick yields one result word with mode, LED and command strobes.
// ----------------------------------------------------------------------------
// A tick's result word is registered at the edge that accepts it. Throughput:
// one tick per cycle; the next tick is taken while the result register still
// waits, as long as that word leaves in the same cycle.
// Reset: synchronous; clears mode to power-on, the time counter, the enable
// latch and the LED, and loads the register defaults (5000, 2000, 3).
`default_nettype none

module power_converter_startup_sequencer_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [pcss_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [pcss_pkg::CfgDataW-1:0]  cfg_data,
  // tick stream in
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // enable_request, dll_locked, adc_cal_valid, pll_locked, pfc_ramp_done,
  // llc_ramp_done, fault_cleared, fault_latched, retry_attempts[7:0],
  // fault_present, zero fill[6:0]
  input  wire logic [pcss_pkg::InW-1:0]      s_tdata,
  // result stream out
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // mode[3:0], led, mode_changed, pfc_start, pfc_stop, llc_stop, pll_reset,
  // ramp_begin, ramp_step, fault_code[1:0], relays_off, balance_update
  output logic [pcss_pkg::OutW-1:0]          m_tdata
);
  import pcss_pkg::*;

  // Configuration registers
  logic [15:0] startup_timeout;
  logic [15:0] pll_timeout;
  logic [7:0]  retry_limit;

  // Sequencer state
  state_t                 state, state_next;
  logic [TimeW-1:0]       time_in_mode, time_in_mode_next;
  logic [SlotCntW-1:0]    slot_tick, slot_tick_next;
  logic [1:0]             slot_mod4, slot_mod4_next;
  logic [SlotMod20W-1:0]  slot_mod20, slot_mod20_next;
  logic                   enable_pending, enable_pending_next;
  logic                   led, led_next;

  in_word_t  tick;
  out_word_t res;
  logic      accept;
  logic      startup_expired;
  logic      pll_expired;
  logic      t_zero;

  assign tick     = in_word_t'(s_tdata);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Timeout compares against the 16-bit limits
  assign t_zero          = (time_in_mode == '0);
  assign startup_expired = (time_in_mode[TimeW-1:16] != '0) ||
                           (time_in_mode[15:0] >= startup_timeout);
  assign pll_expired     = (time_in_mode[TimeW-1:16] != '0) ||
                           (time_in_mode[15:0] >= pll_timeout);

  // Mode handler for the current tick
  always_comb begin
    logic pend;
    pend       = enable_pending || tick.enable_request;
    state_next = state;
    led_next   = led;
    enable_pending_next = pend;
    res        = '0;

    case (state)
      ST_POWERON: begin
        led_next = !led;
        if (tick.dll_locked && tick.adc_cal_valid) begin
          state_next = ST_STANDBY;
        end else if (startup_expired) begin
          state_next = ST_DISABLED;
        end
      end
      ST_STANDBY: begin
        led_next = 1'b1;
        if (pend) begin
          enable_pending_next = 1'b0;
          res.pfc_start       = 1'b1;
          res.pll_reset       = 1'b1;
          state_next          = ST_PLLLOCK;
        end
      end
      ST_PLLLOCK: begin
        led_next = !slot_mod4[1];
        if (tick.pll_locked) begin
          state_next = ST_PFCRAMP;
        end else if (pll_expired) begin
          res.fault_code = FAULT_PLL;
          state_next     = ST_FAULT;
        end
      end
      ST_PFCRAMP: begin
        res.ramp_begin = t_zero;
        res.ramp_step  = 1'b1;
        led_next       = !slot_mod4[0];
        if (tick.pfc_ramp_done) begin
          state_next = ST_LLCRAMP;
        end else if (startup_expired) begin
          res.pfc_stop   = 1'b1;
          res.fault_code = FAULT_STARTUP;
          state_next     = ST_FAULT;
        end
      end
      ST_LLCRAMP: begin
        res.ramp_begin = t_zero;
        res.ramp_step  = 1'b1;
        led_next       = !slot_mod4[1];
        if (tick.llc_ramp_done) begin
          state_next = ST_RUN;
        end else if (startup_expired) begin
          res.llc_stop   = 1'b1;
          res.pfc_stop   = 1'b1;
          res.fault_code = FAULT_STARTUP;
          state_next     = ST_FAULT;
        end
      end
      ST_RUN: begin
        res.balance_update = 1'b1;
      end
      ST_FAULT: begin
        led_next = 1'b1;
        if (tick.fault_cleared) begin
          state_next = ST_STANDBY;
        end else if (tick.fault_latched && (tick.retry_attempts > retry_limit)) begin
          state_next = ST_DISABLED;
        end else if (!tick.fault_present) begin
          res.pfc_start = 1'b1;
          state_next    = ST_PLLLOCK;
        end
      end
      ST_DISABLED: begin
        res.relays_off = 1'b1;
        led_next       = (slot_mod20 < SLOT20_HALF);
      end
      default: begin
        state_next = ST_FAULT;
      end
    endcase

    res.mode         = mode_code(state_next);
    res.led          = led_next;
    res.mode_changed = (state_next != state);
  end

  // Time in mode and blink slot counters; restart on mode change or wrap
  always_comb begin
    time_in_mode_next = time_in_mode + TimeW'(1);
    slot_tick_next    = (slot_tick == SLOT_LAST) ? '0 : slot_tick + SlotCntW'(1);
    slot_mod4_next    = slot_mod4;
    slot_mod20_next   = slot_mod20;
    if (slot_tick == SLOT_LAST) begin
      slot_mod4_next  = slot_mod4 + 2'd1;
      slot_mod20_next = (slot_mod20 == SLOT20_LAST) ? '0 : slot_mod20 + SlotMod20W'(1);
    end
    if (res.mode_changed || (time_in_mode_next == '0)) begin
      time_in_mode_next = '0;
      slot_tick_next    = '0;
      slot_mod4_next    = '0;
      slot_mod20_next   = '0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_timeout <= STARTUP_TIMEOUT_RST;
      pll_timeout     <= PLL_TIMEOUT_RST;
      retry_limit     <= RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STARTUP_TIMEOUT: startup_timeout <= cfg_data[15:0];
        REG_PLL_TIMEOUT:     pll_timeout     <= cfg_data[15:0];
        REG_RETRY_LIMIT:     retry_limit     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_POWERON;
      time_in_mode   <= '0;
      slot_tick      <= '0;
      slot_mod4      <= '0;
      slot_mod20     <= '0;
      enable_pending <= 1'b0;
      led            <= 1'b0;
    end else if (accept) begin
      state          <= state_next;
      time_in_mode   <= time_in_mode_next;
      slot_tick      <= slot_tick_next;
      slot_mod4      <= slot_mod4_next;
      slot_mod20     <= slot_mod20_next;
      enable_pending <= enable_pending_next;
      led            <= led_next;
    end
  end

  // Result register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OutW'(res);
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcss_checker.sv =====
// ----------------------------------------------------------------------------
// pcss_checker
// Port-level checks on the startup sequencer: strobes agree with the mode
// they belong to, and a stalled result word holds.
// ----------------------------------------------------------------------------
`default_nettype none

module pcss_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [pcss_pkg::OutW-1:0] m_tdata
);
  import pcss_pkg::*;

  out_word_t w;
  assign w = out_word_t'(m_tdata);

  // Hold a stalled result word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // A fault code only comes with entry into fault mode
  a_fault_entry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (w.fault_code != FAULT_NONE) |-> (w.mode == MODE_FAULT) && w.mode_changed)
    else $error("fault code without entry into fault mode");

  // PLL reset is issued only with PFC start on the way into PLL lock
  a_pll_reset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && w.pll_reset |-> w.pfc_start && (w.mode == MODE_PLLLOCK) && w.mode_changed)
    else $error("pll reset outside standby exit");

  // Relays off only in disabled mode, which is never left
  a_relays_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && w.relays_off |-> (w.mode == MODE_DISABLED) && !w.mode_changed)
    else $error("relays off outside disabled mode");

  // Balance update only while staying in run mode
  a_balance: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && w.balance_update |-> (w.mode == MODE_RUN) && !w.mode_changed)
    else $error("balance update outside run mode");

endmodule

bind power_converter_startup_sequencer_top pcss_checker u_pcss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
